### hw/rtl/c80dtu_pkg.sv
// Shared types, opcode constants and decode functions for the 8080 data-transfer unit.
`timescale 1ns / 1ps

package c80dtu_pkg;

	localparam logic [7:0] OPC_XCHG  = 8'hEB;
	localparam logic [7:0] OPC_SHLD  = 8'h22;
	localparam logic [7:0] OPC_LHLD  = 8'h2A;
	localparam logic [7:0] OPC_STA   = 8'h32;
	localparam logic [7:0] OPC_LDA   = 8'h3A;
	localparam logic [7:0] OPC_STAXB = 8'h02;
	localparam logic [7:0] OPC_STAXD = 8'h12;
	localparam logic [7:0] OPC_LDAXB = 8'h0A;
	localparam logic [7:0] OPC_LDAXD = 8'h1A;
	localparam logic [7:0] OPC_HLT   = 8'h76;
	localparam logic [7:0] OPC_CALL  = 8'hCD;
	localparam logic [7:0] OPC_JMP   = 8'hC3;
	localparam logic [7:0] OPC_OUT   = 8'hD3;
	localparam logic [7:0] OPC_IN    = 8'hDB;

	localparam logic [7:0] MASK_RP   = 8'b11001111;
	localparam logic [7:0] MASK_DST  = 8'b11000111;
	localparam logic [7:0] MASK_PAIR = 8'b00110000;
	localparam logic [7:0] MASK_GRP  = 8'b11000000;

	localparam logic [7:0] PAT_LXI   = 8'h01;
	localparam logic [7:0] PAT_MVI   = 8'h06;
	localparam logic [7:0] PAT_ALUI  = 8'hC6;
	localparam logic [7:0] PAT_CCALL = 8'hC4;
	localparam logic [7:0] PAT_CJMP  = 8'hC2;
	localparam logic [7:0] PAT_MOV   = 8'h40;

	localparam logic [15:0] SP_RESET = 16'hFFFF;

	localparam logic [2:0] R_B = 3'd0;
	localparam logic [2:0] R_C = 3'd1;
	localparam logic [2:0] R_D = 3'd2;
	localparam logic [2:0] R_E = 3'd3;
	localparam logic [2:0] R_H = 3'd4;
	localparam logic [2:0] R_L = 3'd5;
	localparam logic [2:0] R_M = 3'd6;
	localparam logic [2:0] R_A = 3'd7;

	localparam logic [1:0] RP_BC = 2'd0;
	localparam logic [1:0] RP_DE = 2'd1;
	localparam logic [1:0] RP_HL = 2'd2;
	localparam logic [1:0] RP_SP = 2'd3;

	typedef enum logic [3:0] {
		CL_NONE,
		CL_XCHG,
		CL_SHLD,
		CL_LHLD,
		CL_STA,
		CL_LDA,
		CL_STAX,
		CL_LDAX,
		CL_LXI,
		CL_MVI_R,
		CL_MVI_M,
		CL_MOV_RR,
		CL_MOV_MR,
		CL_MOV_RM
	} op_class_t;

	typedef struct packed {
		logic        re;
		logic        we;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [1:0]  instr_length;
		logic [2:0]  extra_cycles;
		logic [7:0]  acc_value;
		logic [15:0] hl_value;
		logic [15:0] sp_value;
		logic        mem_wrote;
		logic [15:0] write_address;
		logic [7:0]  write_data;
	} result_t;

	function automatic op_class_t decode_class(input logic [7:0] op);
		op_class_t cls;
		cls = CL_NONE;
		if (op == OPC_XCHG)
			cls = CL_XCHG;
		else if (op == OPC_SHLD)
			cls = CL_SHLD;
		else if (op == OPC_LHLD)
			cls = CL_LHLD;
		else if (op == OPC_STA)
			cls = CL_STA;
		else if (op == OPC_LDA)
			cls = CL_LDA;
		else if (op == OPC_STAXB || op == OPC_STAXD)
			cls = CL_STAX;
		else if (op == OPC_LDAXB || op == OPC_LDAXD)
			cls = CL_LDAX;
		else if ((op & MASK_RP) == PAT_LXI)
			cls = CL_LXI;
		else if ((op & MASK_DST) == PAT_MVI)
			cls = (op[5:3] == R_M) ? CL_MVI_M : CL_MVI_R;
		else if ((op & MASK_GRP) == PAT_MOV && op != OPC_HLT) begin
			if (op[5:3] == R_M)
				cls = CL_MOV_MR;
			else if (op[2:0] == R_M)
				cls = CL_MOV_RM;
			else
				cls = CL_MOV_RR;
		end
		return cls;
	endfunction

	function automatic logic [1:0] length_of(input logic [7:0] op);
		logic [1:0] len;
		len = 2'd1;
		if (op == OPC_CALL || op == OPC_JMP || op == OPC_SHLD || op == OPC_LHLD ||
		    op == OPC_STA || op == OPC_LDA || (op & MASK_DST) == PAT_CCALL ||
		    (op & MASK_DST) == PAT_CJMP || (op & MASK_RP) == PAT_LXI)
			len = 2'd3;
		else if (op == OPC_OUT || op == OPC_IN || (op & MASK_DST) == PAT_ALUI ||
		         (op & MASK_DST) == PAT_MVI)
			len = 2'd2;
		return len;
	endfunction

	function automatic logic [2:0] stall_of(input op_class_t cls);
		logic [2:0] st;
		unique case (cls)
			CL_MOV_MR, CL_MOV_RM, CL_MVI_R, CL_LDAX, CL_STAX: st = 3'd1;
			CL_MVI_M, CL_LXI:                                  st = 3'd2;
			CL_LDA, CL_STA:                                    st = 3'd3;
			CL_LHLD, CL_SHLD:                                  st = 3'd4;
			default:                                           st = 3'd0;
		endcase
		return st;
	endfunction

endpackage

### hw/rtl/c80dtu_mem.sv
// Single-port byte memory with registered read and a zeroing sweep after reset.
`timescale 1ns / 1ps

module c80dtu_mem import c80dtu_pkg::*; #(
	parameter int ADDR_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output logic [7:0] rdata,
	output logic     clearing
);

	logic [7:0]           mem [2**ADDR_BITS];
	logic [7:0]           rdata_q;
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 clearing_q;
	logic                 wr_en;
	logic [ADDR_BITS-1:0] wr_addr;
	logic [7:0]           wr_data;

	always_comb begin
		if (clearing_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_data = 8'd0;
		end else begin
			wr_en   = req.we;
			wr_addr = req.addr[ADDR_BITS-1:0];
			wr_data = req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (req.re && !clearing_q)
			rdata_q <= mem[req.addr[ADDR_BITS-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q)
				clearing_q <= 1'b0;
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule

### hw/rtl/c80dtu_exec.sv
// Execute stage: register file, step sequencer and memory request generation.
`timescale 1ns / 1ps

module c80dtu_exec import c80dtu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_opcode,
	input  logic [7:0] in_low,
	input  logic [7:0] in_high,
	input  logic       clearing,
	output mem_req_t   mem_req,
	input  logic [7:0] mem_rdata,
	input  logic       res_free,
	output logic       res_fire,
	output result_t    res
);

	logic        valid_s1;
	logic [7:0]  op_s1;
	logic [7:0]  lo_s1;
	logic [7:0]  hi_s1;
	logic [1:0]  step_q;
	logic [7:0]  tmp_q;
	logic [7:0]  b_q, c_q, d_q, e_q, h_q, l_q, a_q;
	logic [15:0] sp_q;
	logic [15:0] pc_q;

	op_class_t   cls;
	logic [2:0]  dst;
	logic [2:0]  src;
	logic [1:0]  rp;
	logic [15:0] imm;
	logic [15:0] imm_inc;
	logic [15:0] hl;
	logic [15:0] pair;
	logic [7:0]  src_val;
	logic        last;
	logic        go;
	logic        accept;
	logic        is_write;
	mem_req_t    req;
	logic [7:0]  b_n, c_n, d_n, e_n, h_n, l_n, a_n;
	logic [15:0] sp_n;
	logic [7:0]  dst_val;
	logic        dst_wr;

	assign cls     = decode_class(op_s1);
	assign dst     = op_s1[5:3];
	assign src     = op_s1[2:0];
	assign rp      = op_s1[5:4];
	assign imm     = {hi_s1, lo_s1};
	assign imm_inc = imm + 16'd1;
	assign hl      = {h_q, l_q};
	assign pair    = op_s1[4] ? {d_q, e_q} : {b_q, c_q};

	always_comb begin
		unique case (src)
			R_B:     src_val = b_q;
			R_C:     src_val = c_q;
			R_D:     src_val = d_q;
			R_E:     src_val = e_q;
			R_H:     src_val = h_q;
			R_L:     src_val = l_q;
			R_A:     src_val = a_q;
			default: src_val = 8'd0;
		endcase
	end

	always_comb begin
		case (cls)
			CL_LHLD:                                last = (step_q == 2'd2);
			CL_SHLD, CL_LDA, CL_LDAX, CL_MOV_RM:    last = (step_q == 2'd1);
			default:                                last = 1'b1;
		endcase
	end

	assign go       = valid_s1 && (!last || res_free);
	assign res_fire = valid_s1 && last && res_free;
	assign in_ready = !clearing && (!valid_s1 || res_fire);
	assign accept   = in_valid && in_ready;

	always_comb begin
		req       = '0;
		is_write  = 1'b0;
		case (cls)
			CL_SHLD: begin
				req.we    = 1'b1;
				req.addr  = (step_q == 2'd0) ? imm : imm_inc;
				req.wdata = (step_q == 2'd0) ? l_q : h_q;
				is_write  = 1'b1;
			end
			CL_LHLD: begin
				req.re   = (step_q != 2'd2);
				req.addr = (step_q == 2'd0) ? imm : imm_inc;
			end
			CL_STA: begin
				req.we    = 1'b1;
				req.addr  = imm;
				req.wdata = a_q;
				is_write  = 1'b1;
			end
			CL_LDA: begin
				req.re   = (step_q == 2'd0);
				req.addr = imm;
			end
			CL_STAX: begin
				req.we    = 1'b1;
				req.addr  = pair;
				req.wdata = a_q;
				is_write  = 1'b1;
			end
			CL_LDAX: begin
				req.re   = (step_q == 2'd0);
				req.addr = pair;
			end
			CL_MVI_M: begin
				req.we    = 1'b1;
				req.addr  = hl;
				req.wdata = lo_s1;
				is_write  = 1'b1;
			end
			CL_MOV_MR: begin
				req.we    = 1'b1;
				req.addr  = hl;
				req.wdata = src_val;
				is_write  = 1'b1;
			end
			CL_MOV_RM: begin
				req.re   = (step_q == 2'd0);
				req.addr = hl;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_req    = req;
		mem_req.we = req.we && go;
		mem_req.re = req.re && go;
	end

	always_comb begin
		dst_wr  = 1'b0;
		dst_val = 8'd0;
		case (cls)
			CL_MVI_R: begin
				dst_wr  = 1'b1;
				dst_val = lo_s1;
			end
			CL_MOV_RR: begin
				dst_wr  = 1'b1;
				dst_val = src_val;
			end
			CL_MOV_RM: begin
				dst_wr  = 1'b1;
				dst_val = mem_rdata;
			end
			default: ;
		endcase
	end

	always_comb begin
		b_n  = b_q;
		c_n  = c_q;
		d_n  = d_q;
		e_n  = e_q;
		h_n  = h_q;
		l_n  = l_q;
		a_n  = a_q;
		sp_n = sp_q;
		case (cls)
			CL_XCHG: begin
				d_n = h_q;
				e_n = l_q;
				h_n = d_q;
				l_n = e_q;
			end
			CL_LHLD: begin
				l_n = tmp_q;
				h_n = mem_rdata;
			end
			CL_LDA, CL_LDAX: a_n = mem_rdata;
			CL_LXI: begin
				unique case (rp)
					RP_BC: begin
						b_n = hi_s1;
						c_n = lo_s1;
					end
					RP_DE: begin
						d_n = hi_s1;
						e_n = lo_s1;
					end
					RP_HL: begin
						h_n = hi_s1;
						l_n = lo_s1;
					end
					RP_SP: sp_n = imm;
					default: ;
				endcase
			end
			default: ;
		endcase
		if (dst_wr) begin
			unique case (dst)
				R_B:     b_n = dst_val;
				R_C:     c_n = dst_val;
				R_D:     d_n = dst_val;
				R_E:     e_n = dst_val;
				R_H:     h_n = dst_val;
				R_L:     l_n = dst_val;
				R_A:     a_n = dst_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		res.instr_length  = length_of(op_s1);
		res.next_pc       = pc_q + {14'd0, res.instr_length};
		res.extra_cycles  = stall_of(cls);
		res.acc_value     = a_n;
		res.hl_value      = {h_n, l_n};
		res.sp_value      = sp_n;
		res.mem_wrote     = is_write;
		res.write_address = 16'd0;
		res.write_data    = 8'd0;
		if (is_write) begin
			res.write_address = (cls == CL_SHLD) ? imm : req.addr;
			res.write_data    = (cls == CL_SHLD) ? l_q : req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_q   <= 2'd0;
			b_q      <= 8'd0;
			c_q      <= 8'd0;
			d_q      <= 8'd0;
			e_q      <= 8'd0;
			h_q      <= 8'd0;
			l_q      <= 8'd0;
			a_q      <= 8'd0;
			sp_q     <= SP_RESET;
			pc_q     <= 16'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				step_q   <= 2'd0;
			end else if (res_fire) begin
				valid_s1 <= 1'b0;
			end else if (go) begin
				step_q <= step_q + 2'd1;
			end
			if (res_fire) begin
				b_q  <= b_n;
				c_q  <= c_n;
				d_q  <= d_n;
				e_q  <= e_n;
				h_q  <= h_n;
				l_q  <= l_n;
				a_q  <= a_n;
				sp_q <= sp_n;
				pc_q <= res.next_pc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= in_opcode;
			lo_s1 <= in_low;
			hi_s1 <= in_high;
		end
		if (go && !last)
			tmp_q <= mem_rdata;
	end

endmodule

### hw/rtl/cpu8080_data_transfer_unit.sv
// Top level of the 8080 data-transfer unit: execute stage, byte memory, result register.
// A result beat stays in the result register until result_ready takes it; LDA, LDAX,
// MOV r,M, SHLD and LHLD step through their memory accesses before giving their beat.
// Throughput: 1 item per cycle while the result register is free and the memory is not
// being zeroed; item_ready stays low while a stepped item is under way.
// Reset: registers zero, SP 0xFFFF, PC zero; the memory is then zeroed over all
// 2**MEM_ADDR_BITS addresses, during which item_ready stays low.
`timescale 1ns / 1ps

module cpu8080_data_transfer_unit import c80dtu_pkg::*; #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  opcode,
	input  logic [7:0]  low_byte,
	input  logic [7:0]  high_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] next_pc,
	output logic [1:0]  instr_length,
	output logic [2:0]  extra_cycles,
	output logic [7:0]  acc_value,
	output logic [15:0] hl_value,
	output logic [15:0] sp_value,
	output logic        mem_wrote,
	output logic [15:0] write_address,
	output logic [7:0]  write_data
);

	mem_req_t   mem_req;
	logic [7:0] mem_rdata;
	logic       clearing;
	logic       res_fire;
	logic       res_free;
	result_t    res;
	result_t    res_q;
	logic       res_valid_q;

	c80dtu_mem #(
		.ADDR_BITS(MEM_ADDR_BITS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (mem_req),
		.rdata    (mem_rdata),
		.clearing (clearing)
	);

	c80dtu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_valid),
		.in_ready  (item_ready),
		.in_opcode (opcode),
		.in_low    (low_byte),
		.in_high   (high_byte),
		.clearing  (clearing),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_free  (res_free),
		.res_fire  (res_fire),
		.res       (res)
	);

	assign res_free = !res_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_fire)
			res_valid_q <= 1'b1;
		else if (result_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_fire)
			res_q <= res;
	end

	assign result_valid  = res_valid_q;
	assign next_pc       = res_q.next_pc;
	assign instr_length  = res_q.instr_length;
	assign extra_cycles  = res_q.extra_cycles;
	assign acc_value     = res_q.acc_value;
	assign hl_value      = res_q.hl_value;
	assign sp_value      = res_q.sp_value;
	assign mem_wrote     = res_q.mem_wrote;
	assign write_address = res_q.write_address;
	assign write_data    = res_q.write_data;

endmodule
